### hdl/ulim_pkg.sv
// Shared types and constants for the UDP loss and interarrival monitor.
package ulim_pkg;

    localparam int SEQ_W = 32;
    localparam int LEN_W = 16;
    localparam int ARR_W = 48;
    localparam int CNT_W = 32;
    localparam int GAP_W = 31;    // positive gap magnitude
    localparam int DEN_W = 41;    // gap * 1000
    localparam int EXT_W = 64;    // dividend, zero-extended
    localparam int QUO_W = 32;

    localparam logic [LEN_W-1:0] HDR_BYTES = 16'd28;
    localparam logic [9:0]       NS_PER_US = 10'd1000;

    typedef struct packed {
        logic             mode;
        logic [SEQ_W-1:0] sequence_number;
        logic [LEN_W-1:0] payload_length;
        logic [ARR_W-1:0] arrival_time_ns;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0]        report_number;
        logic [CNT_W-1:0]        received_bytes;
        logic [CNT_W-1:0]        min_interval_us;
        logic [CNT_W-1:0]        max_interval_us;
        logic signed [CNT_W-1:0] lost_packets;
    } t_out;

    typedef enum logic {
        CMD_PKT,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic             loss_en;    // previous sequence was nonzero
        logic             sample_en;  // a previous arrival exists
        logic             gap_pos;    // signed gap > 0
        logic [SEQ_W-1:0] gap;
        logic [LEN_W-1:0] len;
    } t_cmd;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_MUL,
        DV_CHK,
        DV_RUN,
        DV_DONE
    } t_div_state;

    typedef enum logic {
        BK_IDLE,
        BK_WAIT
    } t_bk_state;

endpackage

### hdl/ulim_front.sv
// Front end: takes input beats, tracks previous packet, classifies into commands.
module ulim_front #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ulim_pkg::t_in         i_item,
    input  logic                  i_full,
    output logic                  o_push,
    output ulim_pkg::t_cmd        o_cmd,
    output logic [TIME_WIDTH-1:0] o_elapsed
);
    import ulim_pkg::*;

    logic [SEQ_W-1:0]      r_prev_seq, n_prev_seq;
    logic [TIME_WIDTH-1:0] r_prev_arr, n_prev_arr;
    logic                  r_have_prev, n_have_prev;
    logic                  accept;
    logic                  is_pkt;
    logic [TIME_WIDTH-1:0] t_now;
    logic [SEQ_W-1:0]      gap;

    assign accept = i_push & ~i_full;
    assign is_pkt = (i_item.mode == 1'b0) && (i_item.payload_length != '0);
    assign t_now  = TIME_WIDTH'(i_item.arrival_time_ns);
    assign gap    = i_item.sequence_number - r_prev_seq;

    always_comb begin
        n_prev_seq  = r_prev_seq;
        n_prev_arr  = r_prev_arr;
        n_have_prev = r_have_prev;
        o_push      = 1'b0;
        o_cmd.kind      = i_item.mode ? CMD_TICK : CMD_PKT;
        o_cmd.loss_en   = (r_prev_seq != '0);
        o_cmd.sample_en = r_have_prev;
        o_cmd.gap_pos   = ~gap[SEQ_W-1] && (gap != '0);
        o_cmd.gap       = gap;
        o_cmd.len       = i_item.payload_length;
        o_elapsed       = t_now - r_prev_arr;
        if (accept) begin
            if (i_item.mode) begin
                o_push = 1'b1;
            end else if (is_pkt) begin
                o_push      = 1'b1;
                n_prev_seq  = i_item.sequence_number;
                n_prev_arr  = t_now;
                n_have_prev = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_seq  <= '0;
            r_prev_arr  <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_prev_seq  <= n_prev_seq;
            r_prev_arr  <= n_prev_arr;
            r_have_prev <= n_have_prev;
        end
    end

endmodule

### hdl/ulim_cmdq.sv
// Short command queue between front and back ends.
module ulim_cmdq #(
    parameter int WIDTH = 100,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("command queue count overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command pushed into full queue");

endmodule

### hdl/ulim_div.sv
// Iterative divider: elapsed ns / (gap * 1000), saturating to 32 bits.
module ulim_div #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [TIME_WIDTH-1:0]        i_dividend,
    input  logic [ulim_pkg::GAP_W-1:0]   i_gap,
    output logic                         o_done,
    output logic [ulim_pkg::QUO_W-1:0]   o_quotient
);
    import ulim_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

    t_div_state        r_state, n_state;
    logic [GAP_W-1:0]  r_gap, n_gap;
    logic [EXT_W-1:0]  r_ext, n_ext;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DEN_W:0]    trial;
    logic              fits;

    // floor(floor(e / 1000) / g) == floor(e / (1000 * g))
    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_comb begin
        n_state = r_state;
        n_gap   = r_gap;
        n_ext   = r_ext;
        n_den   = r_den;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_step  = r_step;
        o_done  = 1'b0;
        unique case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_gap   = i_gap;
                    n_ext   = EXT_W'(i_dividend);
                    n_state = DV_MUL;
                end
            end
            DV_MUL: begin
                n_den   = DEN_W'(r_gap) * DEN_W'(NS_PER_US);
                n_state = DV_CHK;
            end
            DV_CHK: begin
                // quotient overflows 32 bits iff high word >= divisor
                if (DEN_W'(r_ext[EXT_W-1:QUO_W]) >= r_den) begin
                    n_quo   = '1;
                    n_state = DV_DONE;
                end else begin
                    n_rem   = DEN_W'(r_ext[EXT_W-1:QUO_W]);
                    n_quo   = r_ext[QUO_W-1:0];
                    n_step  = '0;
                    n_state = DV_RUN;
                end
            end
            DV_RUN: begin
                if (fits) begin
                    n_rem = DEN_W'(trial - {1'b0, r_den});
                end else begin
                    n_rem = trial[DEN_W-1:0];
                end
                n_quo  = {r_quo[QUO_W-2:0], fits};
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = DV_DONE;
                end
            end
            DV_DONE: begin
                o_done  = 1'b1;
                n_state = DV_IDLE;
            end
            default: n_state = DV_IDLE;
        endcase
    end

    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap  <= n_gap;
        r_ext  <= n_ext;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_step <= n_step;
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == DV_IDLE)
        else $error("divider started while busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == DV_RUN |-> r_rem < r_den)
        else $error("divider remainder out of range");

endmodule

### hdl/ulim_back.sv
// Back end: executes commands, keeps interval statistics, builds reports.
module ulim_back #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  ulim_pkg::t_cmd               i_cmd,
    input  logic [TIME_WIDTH-1:0]        i_elapsed,
    output logic                         o_q_pop,
    output logic                         o_div_start,
    output logic [TIME_WIDTH-1:0]        o_div_dividend,
    output logic [ulim_pkg::GAP_W-1:0]   o_div_gap,
    input  logic                         i_div_done,
    input  logic [ulim_pkg::QUO_W-1:0]   i_div_quo,
    output logic                         o_valid,
    output ulim_pkg::t_out               o_result,
    input  logic                         i_pop
);
    import ulim_pkg::*;

    localparam logic [CNT_W-1:0] S_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic [CNT_W-1:0] S_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    t_bk_state         r_state, n_state;
    logic [CNT_W-1:0]  r_bytes, n_bytes;
    logic [CNT_W-1:0]  r_min, n_min;
    logic [CNT_W-1:0]  r_max, n_max;
    logic [CNT_W-1:0]  r_loss, n_loss;
    logic [CNT_W-1:0]  r_rpt, n_rpt;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;
    logic [CNT_W:0]    byte_sum;
    logic [CNT_W+1:0]  loss_sum;
    logic              sample_upd;
    logic [QUO_W-1:0]  sample;

    assign byte_sum = {1'b0, r_bytes} + (CNT_W+1)'(i_cmd.len) + (CNT_W+1)'(HDR_BYTES);
    assign loss_sum = {{2{r_loss[CNT_W-1]}}, r_loss}
                    + {{2{i_cmd.gap[SEQ_W-1]}}, i_cmd.gap} - (CNT_W+2)'(1);
    assign o_div_dividend = i_elapsed;
    assign o_div_gap      = i_cmd.gap[GAP_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_bytes     = r_bytes;
        n_min       = r_min;
        n_max       = r_max;
        n_loss      = r_loss;
        n_rpt       = r_rpt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        o_div_start = 1'b0;
        sample_upd  = 1'b0;
        sample      = '0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_cmd.kind == CMD_TICK) begin
                        if (!n_out_valid) begin
                            o_q_pop     = 1'b1;
                            n_rpt       = r_rpt + 1'b1;
                            n_out.report_number   = r_rpt + 1'b1;
                            n_out.received_bytes  = r_bytes;
                            n_out.min_interval_us = r_min;
                            n_out.max_interval_us = r_max;
                            n_out.lost_packets    = r_loss;
                            n_out_valid = 1'b1;
                            n_bytes     = '0;
                            n_min       = '0;
                            n_max       = '0;
                            n_loss      = '0;
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        n_bytes = byte_sum[CNT_W] ? '1 : byte_sum[CNT_W-1:0];
                        if (i_cmd.loss_en) begin
                            if (loss_sum[CNT_W+1:CNT_W-1] == 3'b000 ||
                                loss_sum[CNT_W+1:CNT_W-1] == 3'b111) begin
                                n_loss = loss_sum[CNT_W-1:0];
                            end else if (loss_sum[CNT_W+1]) begin
                                n_loss = S_MIN;
                            end else begin
                                n_loss = S_MAX;
                            end
                        end
                        if (i_cmd.sample_en) begin
                            if (i_cmd.gap_pos) begin
                                o_div_start = 1'b1;
                                n_state     = BK_WAIT;
                            end else begin
                                sample_upd = 1'b1;
                            end
                        end
                    end
                end
            end
            BK_WAIT: begin
                if (i_div_done) begin
                    sample_upd = 1'b1;
                    sample     = i_div_quo;
                    n_state    = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase

        // a zero maximum means no nonzero sample yet this interval
        if (sample_upd) begin
            if (r_max == '0) begin
                n_max = sample;
                n_min = sample;
            end else begin
                if (sample > r_max) begin
                    n_max = sample;
                end
                if (sample < r_min) begin
                    n_min = sample;
                end
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_bytes     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_loss      <= '0;
            r_rpt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bytes     <= n_bytes;
            r_min       <= n_min;
            r_max       <= n_max;
            r_loss      <= n_loss;
            r_rpt       <= n_rpt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_tick_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_cmd.kind == CMD_TICK) |=> r_out_valid)
        else $error("tick popped without a report");

    a_wait_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_WAIT |-> !o_q_pop && !o_div_start)
        else $error("command taken while divide pending");

    a_minmax_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max != '0 |-> r_min <= r_max)
        else $error("interval min above max");

endmodule

### hdl/udp_loss_and_interarrival_monitor.sv
// Top level: UDP loss and interarrival monitor (front, command queue, divider, back).
// A tick beat is queued, then the back end registers its report once any pending one is popped.
// A packet with an interval sample holds the back end while it divides (divisor multiply,
// overflow check, 32 one-bit divide steps unless saturated, update); other beats need no divide.
// A two-entry command queue lets the input take beats while a divide runs.
// Reset (synchronous, active low) clears all counters, statistics and the queue.
module udp_loss_and_interarrival_monitor #(
    parameter int TIME_WIDTH = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  ulim_pkg::t_in   i_item,
    output logic            empty,
    input  logic            pop,
    output ulim_pkg::t_out  o_result
);
    import ulim_pkg::*;

    localparam int Q_W = $bits(t_cmd) + TIME_WIDTH;

    logic                  f_push;
    t_cmd                  f_cmd;
    logic [TIME_WIDTH-1:0] f_elapsed;
    logic [Q_W-1:0]        q_rdata;
    logic                  q_empty;
    logic                  q_pop;
    t_cmd                  q_cmd;
    logic [TIME_WIDTH-1:0] q_elapsed;
    logic                  div_start;
    logic [TIME_WIDTH-1:0] div_dividend;
    logic [GAP_W-1:0]      div_gap;
    logic                  div_done;
    logic [QUO_W-1:0]      div_quo;
    logic                  out_valid;

    ulim_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .i_full    (full),
        .o_push    (f_push),
        .o_cmd     (f_cmd),
        .o_elapsed (f_elapsed)
    );

    ulim_cmdq #(.WIDTH(Q_W), .DEPTH(2)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata ({f_cmd, f_elapsed}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign q_cmd     = q_rdata[Q_W-1:TIME_WIDTH];
    assign q_elapsed = q_rdata[TIME_WIDTH-1:0];

    ulim_div #(.TIME_WIDTH(TIME_WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_gap      (div_gap),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    ulim_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_cmd          (q_cmd),
        .i_elapsed      (q_elapsed),
        .o_q_pop        (q_pop),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_gap      (div_gap),
        .i_div_done     (div_done),
        .i_div_quo      (div_quo),
        .o_valid        (out_valid),
        .o_result       (o_result),
        .i_pop          (pop)
    );

    assign empty = ~out_valid;

endmodule

### tb/sv/udp_loss_and_interarrival_monitor_tb.sv
// Testbench for the UDP loss and interarrival monitor: directed table, random traffic, predictor.
`timescale 1ns / 100ps

module udp_loss_and_interarrival_monitor_tb;
    import ulim_pkg::*;

    localparam int  RANDOM_ITEMS  = 1550;
    localparam int  PHASES        = 4;
    localparam int  LONG_HOLD     = 400;
    localparam int  TAIL_CYCLES   = 200;
    localparam int  PRINT_CAP     = 40;
    localparam longint LOSS_MAX   = 2147483647;
    localparam longint LOSS_MIN   = -longint'(2147483647) - 1;
    localparam t_out NO_REPORT    = '0;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_dir_row;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   push    = 1'b0;
    logic   pop     = 1'b0;
    t_in    i_item  = '0;
    logic   full;
    logic   empty;
    t_out   o_result;

    udp_loss_and_interarrival_monitor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [SEQ_W-1:0] last_seq;
    logic [ARR_W-1:0] last_arrival;
    bit               arrival_seen;
    logic [CNT_W-1:0] byte_count;
    logic [CNT_W-1:0] gap_min_us;
    logic [CNT_W-1:0] gap_max_us;
    longint           loss_count;
    logic [CNT_W-1:0] report_count;

    t_out       report_q[$];
    int         error_count   = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         long_hold_req = 1'b0;
    int         hold_left     = 0;

    // traffic generator state
    logic [SEQ_W-1:0] gen_seq;
    logic [ARR_W-1:0] gen_time;
    int               pkts_to_tick;

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP)
            $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Returns 1 when the beat produces a report.
    function automatic bit monitor_step(input t_in it, output t_out rpt);
        logic [SEQ_W-1:0] diff;
        longint           gap;
        longint           sum;
        logic [ARR_W-1:0] elapsed_ns;
        longint unsigned  elapsed_us;
        longint unsigned  quo;
        longint unsigned  total;
        logic [CNT_W-1:0] sample;
        rpt = '0;
        if (it.mode == CMD_TICK) begin
            report_count = report_count + 1'b1;
            rpt.report_number   = report_count;
            rpt.received_bytes  = byte_count;
            rpt.min_interval_us = gap_min_us;
            rpt.max_interval_us = gap_max_us;
            rpt.lost_packets    = loss_count[CNT_W-1:0];
            byte_count = '0;
            gap_min_us = '0;
            gap_max_us = '0;
            loss_count = 0;
            return 1'b1;
        end
        if (it.payload_length == '0)
            return 1'b0;

        diff = it.sequence_number - last_seq;
        gap  = longint'($signed(diff));
        if (last_seq != '0) begin
            sum = loss_count + gap - 1;
            if (sum > LOSS_MAX)
                sum = LOSS_MAX;
            if (sum < LOSS_MIN)
                sum = LOSS_MIN;
            loss_count = sum;
        end

        if (arrival_seen) begin
            elapsed_ns = it.arrival_time_ns - last_arrival;
            elapsed_us = 64'(elapsed_ns) / 64'd1000;
            quo = (gap > 0) ? elapsed_us / longint'(gap) : 64'd0;
            sample = (quo > 64'hFFFF_FFFF) ? '1 : quo[CNT_W-1:0];
            if (gap_max_us == '0) begin
                gap_max_us = sample;
                gap_min_us = sample;
            end else begin
                if (sample > gap_max_us)
                    gap_max_us = sample;
                if (sample < gap_min_us)
                    gap_min_us = sample;
            end
        end
        last_arrival = it.arrival_time_ns;
        arrival_seen = 1'b1;

        total = 64'(byte_count) + 64'(it.payload_length) + 64'(HDR_BYTES);
        byte_count = (total > 64'hFFFF_FFFF) ? '1 : total[CNT_W-1:0];
        last_seq = it.sequence_number;
        return 1'b0;
    endfunction

    function automatic t_in mk_pkt(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                                   input logic [ARR_W-1:0] t);
        t_in it;
        it.mode            = CMD_PKT;
        it.sequence_number = seq;
        it.payload_length  = len;
        it.arrival_time_ns = t;
        return it;
    endfunction

    // tick with random don't-care fields
    function automatic t_in mk_tick();
        t_in it;
        it.mode            = CMD_TICK;
        it.sequence_number = $urandom;
        it.payload_length  = LEN_W'($urandom);
        it.arrival_time_ns = ARR_W'({$urandom, $urandom});
        return it;
    endfunction

    function automatic t_out mk_report(input logic [CNT_W-1:0] num, input logic [CNT_W-1:0] bytes,
                                       input logic [CNT_W-1:0] lo, input logic [CNT_W-1:0] hi,
                                       input logic [CNT_W-1:0] loss);
        t_out r;
        r.report_number   = num;
        r.received_bytes  = bytes;
        r.min_interval_us = lo;
        r.max_interval_us = hi;
        r.lost_packets    = loss;
        return r;
    endfunction

    task automatic make_random_item(output t_in it);
        int unsigned      pick;
        int unsigned      g;
        logic [SEQ_W-1:0] step;
        logic [ARR_W-1:0] dt;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(99);
        if (pkts_to_tick == 0) begin
            it = mk_tick();
            pkts_to_tick = $urandom_range(1, 24);
        end else if (pick < 6) begin
            // noise: anything at all, either mode
            it = mk_tick();
            it.mode = 1'($urandom_range(1));
        end else if (pick < 10) begin
            it = mk_tick();
            it.mode = CMD_PKT;
            it.payload_length = '0;
        end else begin
            g = $urandom_range(99);
            if (g < 75)
                step = 32'd1;
            else if (g < 85)
                step = $urandom_range(2, 6);
            else if (g < 89)
                step = '0;
            else if (g < 93)
                step = 32'd0 - $urandom_range(1, 3);
            else if (g < 96)
                step = $urandom;
            else begin
                gen_seq = '0;
                step = '0;
            end
            gen_seq = gen_seq + step;

            g = $urandom_range(99);
            if (g < 90)
                dt = $urandom_range(1000, 3_000_000);
            else if (g < 97)
                dt = $urandom_range(0, 999);
            else
                dt = ARR_W'({$urandom, $urandom});
            gen_time = gen_time + dt;

            len = ($urandom_range(9) == 0) ? '1 : LEN_W'($urandom_range(1, 65535));
            it = mk_pkt(gen_seq, len, gen_time);
            pkts_to_tick--;
        end
    endtask

    // Entered and left at a falling edge.
    task automatic send_item(input t_in it, input bit typed, input t_out typed_want);
        t_out rpt;
        bit   has_rpt;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do
            @(posedge i_clk);
        while (full);
        has_rpt = monitor_step(it, rpt);
        if (has_rpt)
            report_q.push_back(typed ? typed_want : rpt);
        @(negedge i_clk);
    endtask

    // always spends at least one falling edge with push low
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(negedge i_clk);
        while (report_q.size() != 0);
    endtask

    task automatic check_report(input t_out got);
        t_out want;
        if (report_q.size() == 0) begin
            report_mismatch($sformatf("report %0d with none expected", got.report_number));
            return;
        end
        want = report_q.pop_front();
        if (got.report_number !== want.report_number)
            report_mismatch($sformatf("report_number %0d, want %0d",
                                      got.report_number, want.report_number));
        if (got.received_bytes !== want.received_bytes)
            report_mismatch($sformatf("report %0d received_bytes %0d, want %0d",
                                      want.report_number, got.received_bytes,
                                      want.received_bytes));
        if (got.min_interval_us !== want.min_interval_us)
            report_mismatch($sformatf("report %0d min_interval_us %0d, want %0d",
                                      want.report_number, got.min_interval_us,
                                      want.min_interval_us));
        if (got.max_interval_us !== want.max_interval_us)
            report_mismatch($sformatf("report %0d max_interval_us %0d, want %0d",
                                      want.report_number, got.max_interval_us,
                                      want.max_interval_us));
        if (got.lost_packets !== want.lost_packets)
            report_mismatch($sformatf("report %0d lost_packets %0d, want %0d",
                                      want.report_number, got.lost_packets,
                                      want.lost_packets));
    endtask

    // result side: pop driven at the falling edge, beats checked at the rising edge
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            check_report(o_result);
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_dir_row dir_rows[$];
        t_in      it;
        int       sent;
        int       idle_tab[PHASES]  = '{0, 79, 0, 16};
        int       stall_tab[PHASES] = '{0, 0, 79, 16};

        last_seq     = '0;
        last_arrival = '0;
        arrival_seen = 1'b0;
        byte_count   = '0;
        gap_min_us   = '0;
        gap_max_us   = '0;
        loss_count   = 0;
        report_count = '0;

        dir_rows.push_back('{mk_tick(), 1'b1, mk_report(1, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_pkt('1, '0, '1), 1'b0, NO_REPORT});    // zero length: ignored
        dir_rows.push_back('{mk_tick(), 1'b1, mk_report(2, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_pkt('0, '1, '0), 1'b0, NO_REPORT});    // first packet, max length
        dir_rows.push_back('{mk_tick(), 1'b1, mk_report(3, 65563, 0, 0, 0)});
        // zero gap gives sample 0, which does not count as a first sample
        dir_rows.push_back('{mk_pkt('0, 16'd1, 48'd5000), 1'b0, NO_REPORT});
        // previous sequence zero: no loss; huge elapsed saturates the sample
        dir_rows.push_back('{mk_pkt(32'd1, 16'd1, '1), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_tick(), 1'b1, mk_report(4, 58, '1, '1, 0)});
        // most negative gap floors the loss; arrival wraps to 1 ns
        dir_rows.push_back('{mk_pkt(32'h8000_0001, 16'd100, '0), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_tick(), 1'b1, mk_report(5, 128, 0, 0, 32'h8000_0000)});
        dir_rows.push_back('{mk_pkt(32'h8000_0003, 16'd72, 48'd1_000_000), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_pkt(32'h8000_0004, 16'd72, 48'd1_300_000), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_pkt(32'h8000_0004, 16'd72, 48'd9_000_000), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_pkt(32'h8000_0008, 16'd72, 48'd19_000_000), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_tick(), 1'b0, NO_REPORT});
        // two largest positive gaps: loss saturates high
        dir_rows.push_back('{mk_pkt(32'd7, 16'd512, 48'hFFFF_0000_0000), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_pkt(32'h8000_0006, 16'd512, 48'hFFFF_FFFF_0000), 1'b0,
                             NO_REPORT});
        dir_rows.push_back('{mk_tick(), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_pkt('0, 16'd28, 48'h0000_0100_0000), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_pkt(32'd5, 16'd28, 48'h0000_0200_0000), 1'b0, NO_REPORT});
        dir_rows.push_back('{mk_tick(), 1'b0, NO_REPORT});

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        wait_drained();

        gen_seq      = $urandom;
        gen_time     = ARR_W'({$urandom, $urandom});
        pkts_to_tick = $urandom_range(1, 24);

        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            if (ph == 0) begin
                // receiver holds off while ticks keep coming: the block fills and stalls input
                @(posedge i_clk);
                long_hold_req = 1'b1;
                @(negedge i_clk);
                for (int k = 0; k < 24; k++) begin
                    if (k % 3 == 2)
                        it = mk_tick();
                    else
                        make_random_item(it);
                    send_item(it, 1'b0, NO_REPORT);
                end
            end
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                make_random_item(it);
                send_item(it, 1'b0, NO_REPORT);
                if (!(it.mode == CMD_PKT && it.payload_length == '0))
                    sent++;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (report_q.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived", report_q.size()));
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
